// File: src/crc8fre_pkg.sv
// Shared types, constants and the CRC-8 step function for the framed request encoder.
`timescale 1ns / 1ps
package crc8fre_pkg;

  // Payload fields on the input channel and the largest length a frame may carry.
  localparam int PayloadFields = 5;
  localparam int MaxPayload    = 5;
  localparam int PayloadLimit  = (MaxPayload < PayloadFields) ? MaxPayload : PayloadFields;

  // CRC-8 generator polynomial, MSB first, initial value zero.
  localparam logic [7:0] CrcPoly = 8'h31;

  // Register select bit of the configuration address.
  localparam logic RegHeader = 1'b0;
  localparam logic RegEnd    = 1'b1;

  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic [7:0]                    function_number;
    logic [2:0]                    payload_length;
    logic [PayloadFields-1:0][7:0] payload;
  } request_t;

  // Frame sequencer states, named after the byte emitted next.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FUNC,
    ST_LEN,
    ST_PAYLOAD,
    ST_CRC,
    ST_END
  } frame_state_t;

  // One byte through the bitwise CRC-8 update.
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/crc8fre_front.sv
// Front end: accepts request items, clamps the length and pushes them into the queue.
`timescale 1ns / 1ps
module crc8fre_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            function_number,
  input  logic [2:0]            payload_length,
  input  logic [7:0]            payload_0,
  input  logic [7:0]            payload_1,
  input  logic [7:0]            payload_2,
  input  logic [7:0]            payload_3,
  input  logic [7:0]            payload_4,
  output logic                  push_valid,
  output crc8fre_pkg::request_t push_data,
  input  logic                  queue_full
);

  logic [2:0] len_clamped;

  // Lengths above the limit are clamped; the clamped value is what gets sent.
  always_comb begin
    if (payload_length > 3'(crc8fre_pkg::PayloadLimit)) begin
      len_clamped = 3'(crc8fre_pkg::PayloadLimit);
    end else begin
      len_clamped = payload_length;
    end
  end

  // Pack the classified request for the queue.
  always_comb begin
    push_data.function_number = function_number;
    push_data.payload_length  = len_clamped;
    push_data.payload[0]      = payload_0;
    push_data.payload[1]      = payload_1;
    push_data.payload[2]      = payload_2;
    push_data.payload[3]      = payload_3;
    push_data.payload[4]      = payload_4;
  end

  assign push_valid = in_valid;
  assign in_stall   = queue_full;

endmodule

// File: src/crc8fre_queue.sv
// Two-entry request queue between the front end and the frame sequencer.
`timescale 1ns / 1ps
module crc8fre_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  crc8fre_pkg::request_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output crc8fre_pkg::request_t head
);

  localparam int PtrW = $clog2(crc8fre_pkg::QueueDepth);
  localparam int CntW = $clog2(crc8fre_pkg::QueueDepth + 1);

  crc8fre_pkg::request_t entries [crc8fre_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntW'(crc8fre_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(crc8fre_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(crc8fre_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/crc8fre_back.sv
// Frame sequencer: walks one request through its frame bytes and computes the CRC.
`timescale 1ns / 1ps
module crc8fre_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            header_byte,
  input  logic [7:0]            end_byte,
  input  logic                  head_valid,
  input  crc8fre_pkg::request_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            frame_byte,
  output logic                  frame_end
);

  crc8fre_pkg::frame_state_t state, state_next;
  crc8fre_pkg::request_t     req, req_next;
  logic [2:0]                remain, remain_next;
  logic [7:0]                crc, crc_next;
  logic                      out_valid_next;
  logic [7:0]                frame_byte_next;
  logic                      frame_end_next;
  logic                      advance;

  // The output register can take a new byte when empty or being drained.
  assign advance = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    if (advance) begin
      unique case (state)
        crc8fre_pkg::ST_IDLE: begin
          if (head_valid) begin
            state_next = crc8fre_pkg::ST_FUNC;
          end
        end
        crc8fre_pkg::ST_FUNC: begin
          state_next = crc8fre_pkg::ST_LEN;
        end
        crc8fre_pkg::ST_LEN: begin
          state_next = (req.payload_length == 3'd0) ? crc8fre_pkg::ST_CRC
                                                    : crc8fre_pkg::ST_PAYLOAD;
        end
        crc8fre_pkg::ST_PAYLOAD: begin
          state_next = (remain == 3'd1) ? crc8fre_pkg::ST_CRC : crc8fre_pkg::ST_PAYLOAD;
        end
        crc8fre_pkg::ST_CRC: begin
          state_next = crc8fre_pkg::ST_END;
        end
        crc8fre_pkg::ST_END: begin
          state_next = crc8fre_pkg::ST_IDLE;
        end
        default: begin
          state_next = crc8fre_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Byte selection, CRC accumulation and payload shifting.
  always_comb begin
    pop             = 1'b0;
    req_next        = req;
    remain_next     = remain;
    crc_next        = crc;
    out_valid_next  = out_valid && out_stall;
    frame_byte_next = frame_byte;
    frame_end_next  = frame_end;
    if (advance) begin
      unique case (state)
        crc8fre_pkg::ST_IDLE: begin
          if (head_valid) begin
            pop             = 1'b1;
            req_next        = head;
            remain_next     = head.payload_length;
            crc_next        = 8'h00;
            out_valid_next  = 1'b1;
            frame_byte_next = header_byte;
            frame_end_next  = 1'b0;
          end
        end
        crc8fre_pkg::ST_FUNC: begin
          crc_next        = crc8fre_pkg::crc_update(crc, req.function_number);
          out_valid_next  = 1'b1;
          frame_byte_next = req.function_number;
          frame_end_next  = 1'b0;
        end
        crc8fre_pkg::ST_LEN: begin
          crc_next        = crc8fre_pkg::crc_update(crc, {5'b0, req.payload_length});
          out_valid_next  = 1'b1;
          frame_byte_next = {5'b0, req.payload_length};
          frame_end_next  = 1'b0;
        end
        crc8fre_pkg::ST_PAYLOAD: begin
          crc_next        = crc8fre_pkg::crc_update(crc, req.payload[0]);
          out_valid_next  = 1'b1;
          frame_byte_next = req.payload[0];
          frame_end_next  = 1'b0;
          remain_next     = remain - 1'b1;
          for (int i = 0; i < crc8fre_pkg::PayloadFields - 1; i++) begin
            req_next.payload[i] = req.payload[i+1];
          end
        end
        crc8fre_pkg::ST_CRC: begin
          out_valid_next  = 1'b1;
          frame_byte_next = crc;
          frame_end_next  = 1'b0;
        end
        crc8fre_pkg::ST_END: begin
          out_valid_next  = 1'b1;
          frame_byte_next = end_byte;
          frame_end_next  = 1'b1;
        end
        default: begin
          out_valid_next = 1'b0;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crc8fre_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req        <= req_next;
    remain     <= remain_next;
    crc        <= crc_next;
    frame_byte <= frame_byte_next;
    frame_end  <= frame_end_next;
  end

endmodule

// File: src/crc8_framed_request_encoder.sv
// Top level of the CRC-8 framed request encoder with its configuration registers.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid / in_stall) takes one request item: a function
// number, a payload length and five payload bytes. Lengths above five clamp
// to five. The output channel (out_valid / out_stall) delivers the frame one
// byte per item: header, function number, length, the payload bytes, the
// CRC-8 (polynomial 0x31, initial zero) and the end byte with frame_end set.
// A frame of L payload bytes is L + 5 output items. The frame sequencer emits
// one byte per cycle unless the receiver stalls, with no gap between frames.
// An item accepted while the sequencer is idle goes into the queue, then into
// the output register as the header byte. A two-entry queue sits between the
// input and the sequencer, so up to two further requests are taken while a
// frame is still going out. When the receiver stalls, the current byte holds
// and the sequencer waits; the input stalls once the queue is full.
// Synchronous reset empties the queue, idles the sequencer and clears the
// header and end registers to zero. Write the registers only while idle.
module crc8_framed_request_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  function_number,
  input  logic [2:0]  payload_length,
  input  logic [7:0]  payload_0,
  input  logic [7:0]  payload_1,
  input  logic [7:0]  payload_2,
  input  logic [7:0]  payload_3,
  input  logic [7:0]  payload_4,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);

  logic [7:0]            header_byte;
  logic [7:0]            end_byte;
  logic                  cfg_write;
  logic                  push_valid;
  crc8fre_pkg::request_t push_data;
  logic                  queue_full;
  logic                  pop;
  logic                  head_valid;
  crc8fre_pkg::request_t head;

  // Configuration port: always ready, registers selected by address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= 8'h00;
      end_byte    <= 8'h00;
    end else if (cfg_write) begin
      unique case (paddr[2])
        crc8fre_pkg::RegHeader: header_byte <= pwdata[7:0];
        crc8fre_pkg::RegEnd:    end_byte    <= pwdata[7:0];
        default:                header_byte <= header_byte;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      crc8fre_pkg::RegHeader: prdata = {24'b0, header_byte};
      crc8fre_pkg::RegEnd:    prdata = {24'b0, end_byte};
      default:                prdata = 32'b0;
    endcase
  end

  crc8fre_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .function_number (function_number),
    .payload_length  (payload_length),
    .payload_0       (payload_0),
    .payload_1       (payload_1),
    .payload_2       (payload_2),
    .payload_3       (payload_3),
    .payload_4       (payload_4),
    .push_valid      (push_valid),
    .push_data       (push_data),
    .queue_full      (queue_full)
  );

  crc8fre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  crc8fre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .header_byte (header_byte),
    .end_byte    (end_byte),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end)
  );

endmodule
